/* rtl/core/apq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_pkg: shared definitions for the array priority queue
// Field widths, operation and status codes, and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package apq_pkg;

    // Default queue depth.
    localparam int APQ_CAPACITY = 16;

    // Fixed field widths.
    localparam int VAL_W  = 32;
    localparam int PRI_W  = 16;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    // Operation codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;        // latch the incoming transaction
        logic              do_insert;   // append the latched pair
        logic              scan_first;  // read entry zero, start the scan
        logic              scan_step;   // compare one entry, read the next
        logic              shift_first; // read the entry behind the winner
        logic              shift_step;  // move one entry down a place
        logic              emit;        // present a result
        logic [STAT_W-1:0] emit_status;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_remove;    // latched operation is a remove
        logic is_full;
        logic is_empty;
        logic scan_last;    // entry under compare is the last stored one
        logic best_is_tail; // winner is the last stored entry
        logic shift_last;   // this move fills the last place
    } t_ctl_sts;

endpackage
`default_nettype wire

/* rtl/core/array_priority_queue.sv */
// Insert, full and empty: result decided in S_DECIDE, strobe from a register.
// Remove with the winner at place B: the scan compares every stored entry,
// then the shift moves each entry behind B down; one memory read and write each.
// A new transaction is accepted in the cycle the result strobe is high.
// Synchronous reset empties the queue; entry contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_priority_queue: bounded priority queue on an unsorted array
// Inserts append at the tail; a remove scans for the highest priority,
// earliest entry first among equals, and closes the gap behind it.
// ----------------------------------------------------------------------------
module array_priority_queue #(
    parameter int CAPACITY = apq_pkg::APQ_CAPACITY
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              i_cmd,
    input  wire signed [apq_pkg::VAL_W-1:0]  i_item_value,
    input  wire signed [apq_pkg::PRI_W-1:0]  i_item_priority,
    output logic                             o_valid,
    output logic [apq_pkg::STAT_W-1:0]       o_status,
    output logic signed [apq_pkg::VAL_W-1:0] o_removed_value,
    output logic signed [apq_pkg::PRI_W-1:0] o_removed_priority,
    output logic [apq_pkg::OCC_W-1:0]        o_occupancy
);
    import apq_pkg::*;

    t_ctl_cmd ctl;
    t_ctl_sts sts;

    // Sequencer.
    apq_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // Storage and datapath.
    apq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .o_sts              (sts),
        .i_cmd              (i_cmd),
        .i_item_value       (i_item_value),
        .i_item_priority    (i_item_priority),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_removed_value    (o_removed_value),
        .o_removed_priority (o_removed_priority),
        .o_occupancy        (o_occupancy)
    );

endmodule
`default_nettype wire

/* rtl/core/apq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_datapath: entry storage, scan and shift datapath
// Holds the entry memories, the occupancy count, the running maximum of a
// scan and the result register. One memory read and one write per cycle.
// ----------------------------------------------------------------------------
module apq_datapath #(
    parameter int CAPACITY = apq_pkg::APQ_CAPACITY
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire apq_pkg::t_ctl_cmd              i_ctl,
    output apq_pkg::t_ctl_sts                   o_sts,
    input  wire                                 i_cmd,
    input  wire signed [apq_pkg::VAL_W-1:0]     i_item_value,
    input  wire signed [apq_pkg::PRI_W-1:0]     i_item_priority,
    output logic                                o_valid,
    output logic [apq_pkg::STAT_W-1:0]          o_status,
    output logic signed [apq_pkg::VAL_W-1:0]    o_removed_value,
    output logic signed [apq_pkg::PRI_W-1:0]    o_removed_priority,
    output logic [apq_pkg::OCC_W-1:0]           o_occupancy
);
    import apq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Entry storage.
    logic [VAL_W-1:0] mem_val [CAPACITY];
    logic [PRI_W-1:0] mem_pri [CAPACITY];

    // Latched transaction.
    logic                    r_cmd;
    logic [VAL_W-1:0]        r_val;
    logic [PRI_W-1:0]        r_pri;

    // Control and datapath registers.
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [CW-1:0]           r_scan_idx;
    logic [IW-1:0]           r_cmp_idx;
    logic [IW-1:0]           r_best_idx;
    logic signed [PRI_W-1:0] r_best_pri;
    logic [VAL_W-1:0]        r_best_val;
    logic [IW-1:0]           r_wr_idx;
    logic [VAL_W-1:0]        r_rd_val;
    logic signed [PRI_W-1:0] r_rd_pri;
    logic                    r_out_valid;

    // Read and write port controls.
    logic                    rd_en;
    logic [IW-1:0]           rd_addr;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [VAL_W-1:0]        wr_val;
    logic [PRI_W-1:0]        wr_pri;
    logic [CW-1:0]           scan_next;
    logic [CW-1:0]           shift_rd;
    logic                    take_best;
    logic [CW+OCC_W-1:0]     occ_ext;

    assign scan_next = r_scan_idx;
    assign shift_rd  = CW'(r_wr_idx) + CW'(2);

    // The first entry always seeds the maximum; later ones win only when
    // strictly larger, so the earliest entry wins a tie.
    assign take_best = (r_cmp_idx == '0) || (r_rd_pri > r_best_pri);

    // Status back to the controller.
    always_comb begin
        o_sts.is_remove    = (r_cmd == CMD_REMOVE);
        o_sts.is_full      = (r_count == CW'(CAPACITY));
        o_sts.is_empty     = (r_count == '0);
        o_sts.scan_last    = (CW'(r_cmp_idx) == r_count - CW'(1));
        o_sts.best_is_tail = (CW'(r_best_idx) == r_count - CW'(1));
        o_sts.shift_last   = (CW'(r_wr_idx) == r_count - CW'(2));
    end

    // Read port select.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        priority if (i_ctl.scan_first) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (i_ctl.scan_step) begin
            rd_en   = (scan_next < r_count);
            rd_addr = scan_next[IW-1:0];
        end else if (i_ctl.shift_first) begin
            rd_en   = 1'b1;
            rd_addr = r_best_idx + IW'(1);
        end else if (i_ctl.shift_step) begin
            rd_en   = (shift_rd < r_count);
            rd_addr = shift_rd[IW-1:0];
        end
    end

    // Write port select: append on insert, move down on shift.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_val  = r_val;
        wr_pri  = r_pri;
        priority if (i_ctl.do_insert) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IW-1:0];
        end else if (i_ctl.shift_step) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_idx;
            wr_val  = r_rd_val;
            wr_pri  = r_rd_pri;
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_val[wr_addr] <= wr_val;
            mem_pri[wr_addr] <= wr_pri;
        end
        if (rd_en) begin
            r_rd_val <= mem_val[rd_addr];
            r_rd_pri <= mem_pri[rd_addr];
        end
    end

    // Latch the transaction when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_val <= i_item_value;
            r_pri <= i_item_priority;
        end
    end

    // Scan and shift indexes, and the running maximum.
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_first) begin
            r_cmp_idx  <= '0;
            r_scan_idx <= CW'(1);
        end
        if (i_ctl.scan_step) begin
            r_cmp_idx  <= r_cmp_idx + IW'(1);
            r_scan_idx <= r_scan_idx + CW'(1);
            if (take_best) begin
                r_best_idx <= r_cmp_idx;
                r_best_pri <= r_rd_pri;
                r_best_val <= r_rd_val;
            end
        end
        if (i_ctl.shift_first) begin
            r_wr_idx <= r_best_idx;
        end
        if (i_ctl.shift_step) begin
            r_wr_idx <= r_wr_idx + IW'(1);
        end
    end

    // Next occupancy count.
    always_comb begin
        n_count = r_count;
        if (i_ctl.do_insert) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.emit && (i_ctl.emit_status == ST_REMOVED)) begin
            n_count = r_count - CW'(1);
        end
    end

    assign occ_ext = (CW + OCC_W)'(n_count);

    // Count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= i_ctl.emit;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_status    <= i_ctl.emit_status;
            o_occupancy <= occ_ext[OCC_W-1:0];
            if (i_ctl.emit_status == ST_REMOVED) begin
                o_removed_value    <= r_best_val;
                o_removed_priority <= r_best_pri;
            end else begin
                o_removed_value    <= '0;
                o_removed_priority <= '0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

/* rtl/core/apq_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apq_controller: operation sequencer for the array priority queue
// Accepts one transaction at a time and steps the datapath through the
// insert, or the scan and shift of a remove, then requests the result.
// ----------------------------------------------------------------------------
module apq_controller (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  wire apq_pkg::t_ctl_sts i_sts,
    output apq_pkg::t_ctl_cmd      o_ctl
);
    import apq_pkg::*;

    localparam logic [2:0] S_IDLE        = 3'd0;
    localparam logic [2:0] S_DECIDE      = 3'd1;
    localparam logic [2:0] S_SCAN        = 3'd2;
    localparam logic [2:0] S_SHIFT_START = 3'd3;
    localparam logic [2:0] S_SHIFT       = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.is_remove) begin
                    o_ctl.emit = 1'b1;
                    if (i_sts.is_full) begin
                        o_ctl.emit_status = ST_FULL;
                    end else begin
                        o_ctl.do_insert   = 1'b1;
                        o_ctl.emit_status = ST_INSERTED;
                    end
                    n_state = S_IDLE;
                end else if (i_sts.is_empty) begin
                    o_ctl.emit        = 1'b1;
                    o_ctl.emit_status = ST_EMPTY;
                    n_state           = S_IDLE;
                end else begin
                    o_ctl.scan_first = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SHIFT_START;
                end
            end
            S_SHIFT_START: begin
                if (i_sts.best_is_tail) begin
                    o_ctl.emit        = 1'b1;
                    o_ctl.emit_status = ST_REMOVED;
                    n_state           = S_IDLE;
                end else begin
                    o_ctl.shift_first = 1'b1;
                    n_state           = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_ctl.shift_step = 1'b1;
                if (i_sts.shift_last) begin
                    o_ctl.emit        = 1'b1;
                    o_ctl.emit_status = ST_REMOVED;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for array_priority_queue
// Drives insert and remove transactions through the start/busy handshake,
// keeps a mirror of the queue contents to predict every result, and checks
// each strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import apq_pkg::*;

    localparam int QDEPTH = APQ_CAPACITY;

    // One predicted result of a queue operation.
    typedef struct {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
        logic [OCC_W-1:0]        occupancy;
    } t_queue_outcome;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    i_cmd = CMD_INSERT;
    logic signed [VAL_W-1:0] i_item_value = '0;
    logic signed [PRI_W-1:0] i_item_priority = '0;
    wire                     busy;
    wire                     o_valid;
    wire [STAT_W-1:0]        o_status;
    wire signed [VAL_W-1:0]  o_removed_value;
    wire signed [PRI_W-1:0]  o_removed_priority;
    wire [OCC_W-1:0]         o_occupancy;

    // Mirror of the stored entries, in arrival order.
    logic signed [VAL_W-1:0] mirror_value [QDEPTH];
    logic signed [PRI_W-1:0] mirror_prio [QDEPTH];
    int                      mirror_count = 0;

    t_queue_outcome queue_outcomes [$];
    int             mismatch_count = 0;
    bit             sender_idles = 1'b1;

    array_priority_queue #(
        .CAPACITY(QDEPTH)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_item_value       (i_item_value),
        .i_item_priority    (i_item_priority),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_removed_value    (o_removed_value),
        .o_removed_priority (o_removed_priority),
        .o_occupancy        (o_occupancy)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one operation to the mirror and returns the result it must give.
    function automatic t_queue_outcome predict_queue_op(
        input logic                    cmd,
        input logic signed [VAL_W-1:0] val,
        input logic signed [PRI_W-1:0] prio
    );
        t_queue_outcome res;
        int             best;
        res.value = '0;
        res.prio  = '0;
        if (cmd == CMD_INSERT) begin
            if (mirror_count >= QDEPTH) begin
                res.status = ST_FULL;
            end else begin
                mirror_value[mirror_count] = val;
                mirror_prio[mirror_count]  = prio;
                mirror_count++;
                res.status = ST_INSERTED;
            end
        end else if (mirror_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            // Strictly greater wins, so the earliest entry keeps a tie.
            best = 0;
            for (int i = 1; i < mirror_count; i++) begin
                if (mirror_prio[i] > mirror_prio[best]) begin
                    best = i;
                end
            end
            res.value = mirror_value[best];
            res.prio  = mirror_prio[best];
            for (int i = best; i + 1 < mirror_count; i++) begin
                mirror_value[i] = mirror_value[i + 1];
                mirror_prio[i]  = mirror_prio[i + 1];
            end
            mirror_count--;
            res.status = ST_REMOVED;
        end
        res.occupancy = mirror_count[OCC_W-1:0];
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, what, got, want);
    endtask

    // Sends one transaction, with an optional random gap in front of it, and
    // records its predicted result at the accepting edge.
    task automatic send_item(input logic cmd, input logic signed [VAL_W-1:0] val,
                             input logic signed [PRI_W-1:0] prio);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, 5);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_item_value    <= val;
        i_item_priority <= prio;
        do @(posedge i_clk); while (busy);
        queue_outcomes.push_back(predict_queue_op(cmd, val, prio));
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic wait_results_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (queue_outcomes.size() != 0);
    endtask

    // Compares each strobed result with the oldest prediction.
    always @(posedge i_clk) begin
        t_queue_outcome exp_res;
        if (i_rst_n && o_valid) begin
            if (queue_outcomes.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, '0);
            end else begin
                exp_res = queue_outcomes.pop_front();
                if (o_status !== exp_res.status)
                    report_mismatch("status", o_status, exp_res.status);
                if (o_removed_value !== exp_res.value)
                    report_mismatch("removed value", o_removed_value, exp_res.value);
                if (o_removed_priority !== exp_res.prio)
                    report_mismatch("removed priority", o_removed_priority,
                                    exp_res.prio);
                if (o_occupancy !== exp_res.occupancy)
                    report_mismatch("occupancy", o_occupancy, exp_res.occupancy);
            end
        end
    end

    // Random value, leaning on the extremes now and then.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return (($urandom_range(1)) != 0) ? 32'sh0 : -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // Random priority: a narrow band to force ties, extremes, or anything.
    function automatic logic signed [PRI_W-1:0] pick_priority();
        case ($urandom_range(9))
            0, 1, 2: return PRI_W'($urandom_range(3) - 2);
            3: return 16'sh8000;
            4: return 16'sh7fff;
            default: return PRI_W'($urandom_range(16'hffff));
        endcase
    endfunction

    // A remove on the empty queue right after reset, and once more.
    task automatic test_remove_on_empty();
        send_item(CMD_REMOVE, 32'sh7fff_ffff, 16'sh7fff);
        send_item(CMD_REMOVE, 32'sh8000_0000, 16'sh8000);
    endtask

    // Fills the queue with extreme values and repeated priorities, then
    // offers one more pair, which must be dropped.
    task automatic test_fill_to_full();
        logic signed [VAL_W-1:0] vals [QDEPTH] = '{
            32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
            32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0001, 32'sh1234_5678,
            32'shfedc_ba98, 32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh0000_ffff,
            32'shffff_0000, 32'sh3c3c_3c3c, 32'shc3c3_c3c3, 32'sh7fff_fffe};
        logic signed [PRI_W-1:0] pris [QDEPTH] = '{
            16'sh8000, 16'sh0005, 16'sh7fff, 16'sh0000,
            16'sh7fff, -16'sd1,   16'sh0005, 16'sh7fff,
            16'sh8000, 16'sh0000, 16'sh0001, 16'sh7ffe,
            16'sh5555, 16'shaaaa, -16'sd1,   16'sh7fff};
        foreach (vals[i]) begin
            send_item(CMD_INSERT, vals[i], pris[i]);
        end
        send_item(CMD_INSERT, 32'sh0bad_0bad, 16'sh7fff);
        wait_results_drained();
    endtask

    // Removes from the full queue: the equal top priorities must leave in
    // arrival order, and the winner at the tail needs no shift.
    task automatic test_tie_order();
        repeat (5) begin
            send_item(CMD_REMOVE, $urandom(), PRI_W'($urandom_range(16'hffff)));
        end
    endtask

    // Random traffic in phases that lean toward filling or toward draining,
    // so that both the full and the empty queue come up again and again.
    task automatic test_random_traffic(input int n_items);
        bit fill_phase;
        int phase_left;
        fill_phase = 1'b1;
        phase_left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (phase_left == 0) begin
                fill_phase = ~fill_phase;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            // One long stretch without any sender gaps.
            sender_idles = !(k >= n_items / 3 && k < n_items / 3 + 150);
            if (k == n_items / 2) begin
                wait_results_drained();
            end
            if ($urandom_range(99) < (fill_phase ? 75 : 25)) begin
                send_item(CMD_INSERT, pick_value(), pick_priority());
            end else begin
                send_item(CMD_REMOVE, pick_value(), pick_priority());
            end
        end
        sender_idles = 1'b1;
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_remove_on_empty();
        test_fill_to_full();
        test_tie_order();
        test_random_traffic(480);
        wait_results_drained();
        repeat (2 * QDEPTH + 8) @(posedge i_clk);
        if (queue_outcomes.size() != 0) begin
            report_mismatch("results never seen", queue_outcomes.size(), '0);
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
